[design/assert_macros.svh]
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cons holds at every edge where ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/acir_pkg.sv]
package acir_pkg;

    localparam int unsigned FRAME_BITS = 28;
    localparam int unsigned POS_W      = 6;

    localparam logic [7:0]  SIGNATURE  = 8'h88;
    localparam logic [27:0] OFF_WORD   = 28'h88C0051;

    localparam logic [7:0]  TEMP_MIN    = 8'd16;
    localparam logic [7:0]  TEMP_MAX    = 8'd30;
    localparam logic [7:0]  TEMP_OFFSET = 8'd15;

    localparam logic [14:0] HDR_MARK_US   = 15'd8500;
    localparam logic [14:0] HDR_SPACE_US  = 15'd4250;
    localparam logic [14:0] BIT_MARK_US   = 15'd550;
    localparam logic [14:0] ONE_SPACE_US  = 15'd1600;
    localparam logic [14:0] ZERO_SPACE_US = 15'd550;
    localparam logic [14:0] GAP_US        = 15'd19980;
    localparam logic [15:0] CARRIER_HZ    = 16'd38000;

    // Positions of the special entries within the 60-entry frame.
    localparam logic [POS_W-1:0] POS_HDR_MARK  = 6'd0;
    localparam logic [POS_W-1:0] POS_HDR_SPACE = 6'd1;
    localparam logic [POS_W-1:0] POS_GAP       = 6'd59;

    localparam logic [2:0] MODE_COOL = 3'd0;
    localparam logic [2:0] MODE_DRY  = 3'd1;
    localparam logic [2:0] MODE_FAN  = 3'd2;
    localparam logic [2:0] MODE_AUTO = 3'd3;
    localparam logic [2:0] MODE_HEAT = 3'd4;

    localparam logic [2:0] FAN_CODE_AUTO = 3'd0;
    localparam logic [2:0] FAN_CODE_LOW  = 3'd1;
    localparam logic [2:0] FAN_CODE_MED  = 3'd2;
    localparam logic [2:0] FAN_CODE_HIGH = 3'd3;

    localparam logic [3:0] FAN_VAL_AUTO = 4'd5;
    localparam logic [3:0] FAN_VAL_LOW  = 4'd1;
    localparam logic [3:0] FAN_VAL_MED  = 4'd2;
    localparam logic [3:0] FAN_VAL_HIGH = 4'd4;

    function automatic logic [2:0] decode_mode(input logic [2:0] code);
        logic [2:0] val;
        case (code)
            MODE_COOL: val = MODE_COOL;
            MODE_DRY:  val = MODE_DRY;
            MODE_FAN:  val = MODE_FAN;
            MODE_AUTO: val = MODE_AUTO;
            MODE_HEAT: val = MODE_HEAT;
            default:   val = MODE_AUTO;
        endcase
        return val;
    endfunction

    function automatic logic [3:0] map_fan(input logic [2:0] code);
        logic [3:0] val;
        case (code)
            FAN_CODE_AUTO: val = FAN_VAL_AUTO;
            FAN_CODE_LOW:  val = FAN_VAL_LOW;
            FAN_CODE_MED:  val = FAN_VAL_MED;
            FAN_CODE_HIGH: val = FAN_VAL_HIGH;
            default:       val = FAN_VAL_AUTO;
        endcase
        return val;
    endfunction

endpackage

[design/acir_cmd_if.sv]
interface acir_cmd_if;
    logic       valid;
    logic       ready;
    logic       power_on;
    logic [2:0] mode_code;
    logic [2:0] fan_code;
    logic [7:0] temp_celsius;

    modport source (output valid, power_on, mode_code, fan_code, temp_celsius, input ready);
    modport sink   (input valid, power_on, mode_code, fan_code, temp_celsius, output ready);
endinterface

[design/acir_pulse_if.sv]
interface acir_pulse_if;
    logic        valid;
    logic        ready;
    logic [14:0] duration_us;
    logic        is_mark;
    logic        last;
    logic [15:0] carrier_hz;

    modport source (output valid, duration_us, is_mark, last, carrier_hz, input ready);
    modport sink   (input valid, duration_us, is_mark, last, carrier_hz, output ready);
endinterface

[design/ac_ir_frame_encoder.sv]
// Air-conditioner IR frame encoder.
// The cmd channel takes one command per transfer: power, mode, fan and temperature.
// The pulse channel returns the frame as 60 entries in order: header mark and
// space, a mark and a space for each of the 28 word bits MSB first, a footer
// mark and the trailing gap, which carries last. carrier_hz is always 38000.
// A command passes the mapping stage, the word stage, the frame serializer and
// the output register. Throughput: one entry per cycle while the receiver is
// ready; a frame is sent whole before the next starts. Two further commands
// can wait in the mapping and word stages while a frame is being sent, so cmd
// stays ready until those stages are full.
// Reset clears every valid bit; nothing is in flight afterwards.
// When the receiver stalls, the current entry holds on the port and the
// serializer and the stages behind it wait, losing and repeating nothing.
`include "assert_macros.svh"

module ac_ir_frame_encoder (
    input  logic                clk,
    input  logic                rst_n,
    acir_cmd_if.sink            cmd,
    acir_pulse_if.source        pulse
);

    // Stage 1: mapped and clamped fields.
    logic       s1_valid_reg;
    logic       s1_power_reg;
    logic [2:0] s1_mode_reg;
    logic [3:0] s1_fan_reg;
    logic [3:0] s1_temp_reg;

    // Stage 2: assembled 28-bit word.
    logic                                s2_valid_reg;
    logic [acir_pkg::FRAME_BITS-1:0]     s2_word_reg;

    // Stage 3: frame serializer.
    logic                                ser_valid_reg;
    logic [acir_pkg::FRAME_BITS-1:0]     ser_word_reg;
    logic [acir_pkg::FRAME_BITS-1:0]     ser_word_next;
    logic [acir_pkg::POS_W-1:0]          ser_pos_reg;

    // Output register.
    logic        out_valid_reg;
    logic [14:0] out_dur_reg;
    logic        out_mark_reg;
    logic        out_last_reg;

    logic        ser_take;
    logic        ser_done;
    logic        ser_load;
    logic        s2_free;
    logic        s1_free;

    logic [7:0]  temp_clamped;
    logic [3:0]  s1_temp_next;
    logic [3:0]  chk;
    logic [acir_pkg::FRAME_BITS-1:0] word_next;

    logic [14:0] ent_dur;
    logic        ent_mark;
    logic        ent_last;

    assign ser_take = ser_valid_reg && (!out_valid_reg || pulse.ready);
    assign ser_done = ser_take && (ser_pos_reg == acir_pkg::POS_GAP);
    assign ser_load = s2_valid_reg && (!ser_valid_reg || ser_done);
    assign s2_free  = !s2_valid_reg || ser_load;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign cmd.ready = s1_free;

    always_comb
    begin
        if (cmd.temp_celsius < acir_pkg::TEMP_MIN)
        begin
            temp_clamped = acir_pkg::TEMP_MIN;
        end
        else if (cmd.temp_celsius > acir_pkg::TEMP_MAX)
        begin
            temp_clamped = acir_pkg::TEMP_MAX;
        end
        else
        begin
            temp_clamped = cmd.temp_celsius;
        end
    end

    assign s1_temp_next = 4'(temp_clamped - acir_pkg::TEMP_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && cmd.valid)
        begin
            s1_power_reg <= cmd.power_on;
            s1_mode_reg  <= acir_pkg::decode_mode(cmd.mode_code);
            s1_fan_reg   <= acir_pkg::map_fan(cmd.fan_code);
            s1_temp_reg  <= s1_temp_next;
        end
    end

    // The mode nibble and the power nibble above it are zero apart from mode.
    assign chk = s1_fan_reg + s1_temp_reg + {1'b0, s1_mode_reg};

    always_comb
    begin
        if (s1_power_reg)
        begin
            word_next = {acir_pkg::SIGNATURE, 5'b00000, s1_mode_reg,
                         s1_temp_reg, s1_fan_reg, chk};
        end
        else
        begin
            word_next = acir_pkg::OFF_WORD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_word_reg <= word_next;
        end
    end

    // Entry decode: even positions are marks, odd positions between the
    // header space and the gap are data spaces that take the word's top bit.
    always_comb
    begin
        ent_mark = !ser_pos_reg[0];
        ent_last = 1'b0;
        case (ser_pos_reg)
            acir_pkg::POS_HDR_MARK:  ent_dur = acir_pkg::HDR_MARK_US;
            acir_pkg::POS_HDR_SPACE: ent_dur = acir_pkg::HDR_SPACE_US;
            acir_pkg::POS_GAP:
            begin
                ent_dur  = acir_pkg::GAP_US;
                ent_last = 1'b1;
            end
            default:
            begin
                if (!ser_pos_reg[0])
                begin
                    ent_dur = acir_pkg::BIT_MARK_US;
                end
                else if (ser_word_reg[acir_pkg::FRAME_BITS-1])
                begin
                    ent_dur = acir_pkg::ONE_SPACE_US;
                end
                else
                begin
                    ent_dur = acir_pkg::ZERO_SPACE_US;
                end
            end
        endcase
    end

    always_comb
    begin
        ser_word_next = ser_word_reg;
        if (ser_load)
        begin
            ser_word_next = s2_word_reg;
        end
        else if (ser_take && ser_pos_reg[0] && (ser_pos_reg != acir_pkg::POS_HDR_SPACE)
                 && (ser_pos_reg != acir_pkg::POS_GAP))
        begin
            ser_word_next = {ser_word_reg[acir_pkg::FRAME_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_pos_reg   <= acir_pkg::POS_HDR_MARK;
        end
        else if (ser_load)
        begin
            ser_valid_reg <= 1'b1;
            ser_pos_reg   <= acir_pkg::POS_HDR_MARK;
        end
        else if (ser_done)
        begin
            ser_valid_reg <= 1'b0;
            ser_pos_reg   <= acir_pkg::POS_HDR_MARK;
        end
        else if (ser_take)
        begin
            ser_pos_reg <= ser_pos_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_word_reg <= ser_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pulse.ready)
        begin
            out_valid_reg <= ser_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take)
        begin
            out_dur_reg  <= ent_dur;
            out_mark_reg <= ent_mark;
            out_last_reg <= ent_last;
        end
    end

    assign pulse.valid       = out_valid_reg;
    assign pulse.duration_us = out_dur_reg;
    assign pulse.is_mark     = out_mark_reg;
    assign pulse.last        = out_last_reg;
    assign pulse.carrier_hz  = acir_pkg::CARRIER_HZ;

    `ASSERT_ALWAYS(a_pos_range, clk, rst_n, ser_pos_reg <= acir_pkg::POS_GAP,
        "serializer position past the gap")

    `ASSERT_IMPLIES(a_last_is_gap, clk, rst_n, pulse.valid && pulse.last,
        !pulse.is_mark && (pulse.duration_us == acir_pkg::GAP_US), "last entry is not the gap")

    `ASSERT_IMPLIES(a_mark_len, clk, rst_n, pulse.valid && pulse.is_mark,
        (pulse.duration_us == acir_pkg::HDR_MARK_US) ||
        (pulse.duration_us == acir_pkg::BIT_MARK_US), "mark with a bad length")

    `ASSERT_IMPLIES(a_load_idle, clk, rst_n, ser_load && ser_valid_reg,
        ser_pos_reg == acir_pkg::POS_GAP, "new frame loaded over an unfinished one")

endmodule

[test/ac_ir_frame_encoder_tb.sv]
module ac_ir_frame_encoder_tb;

    typedef struct packed {
        logic [14:0] duration_us;
        logic        is_mark;
        logic        last;
        logic [15:0] carrier_hz;
    } pulse_entry_t;

    typedef struct packed {
        logic        power_on;
        logic [2:0]  mode_code;
        logic [2:0]  fan_code;
        logic [7:0]  temp_celsius;
        logic        word_given;
        logic [27:0] word;
    } cmd_row_t;

    localparam int NUM_DIRECTED = 16;
    localparam int NUM_RANDOM   = 234;

    // Rows with word_given set carry the frame word worked out by hand.
    localparam cmd_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{1'b0, acir_pkg::MODE_COOL, acir_pkg::FAN_CODE_AUTO, 8'd0,   1'b1, acir_pkg::OFF_WORD},
        '{1'b0, 3'd7,                3'd7,                    8'd255, 1'b1, acir_pkg::OFF_WORD},
        '{1'b1, acir_pkg::MODE_COOL, acir_pkg::FAN_CODE_AUTO, 8'd16,  1'b1, 28'h8800156},
        '{1'b1, acir_pkg::MODE_HEAT, acir_pkg::FAN_CODE_HIGH, 8'd30,  1'b1, 28'h8804F47},
        '{1'b1, 3'd7,                3'd7,                    8'd0,   1'b1, 28'h8803159},
        '{1'b1, 3'd5,                3'd4,                    8'd255, 1'b1, 28'h8803F57},
        '{1'b1, acir_pkg::MODE_DRY,  acir_pkg::FAN_CODE_LOW,  8'd15,  1'b0, 28'h0},
        '{1'b1, acir_pkg::MODE_FAN,  acir_pkg::FAN_CODE_MED,  8'd17,  1'b0, 28'h0},
        '{1'b1, acir_pkg::MODE_AUTO, acir_pkg::FAN_CODE_HIGH, 8'd29,  1'b0, 28'h0},
        '{1'b1, 3'd6,                3'd5,                    8'd31,  1'b0, 28'h0},
        '{1'b1, acir_pkg::MODE_HEAT, 3'd6,                    8'd22,  1'b0, 28'h0},
        '{1'b1, acir_pkg::MODE_COOL, acir_pkg::FAN_CODE_LOW,  8'd128, 1'b0, 28'h0},
        '{1'b0, acir_pkg::MODE_HEAT, acir_pkg::FAN_CODE_HIGH, 8'd24,  1'b0, 28'h0},
        '{1'b1, acir_pkg::MODE_DRY,  acir_pkg::FAN_CODE_AUTO, 8'd20,  1'b0, 28'h0},
        '{1'b1, acir_pkg::MODE_FAN,  acir_pkg::FAN_CODE_HIGH, 8'd25,  1'b0, 28'h0},
        '{1'b1, 3'd5,                acir_pkg::FAN_CODE_MED,  8'd127, 1'b0, 28'h0}
    };

    logic clk;
    logic rst_n;

    acir_cmd_if   cmd_bus ();
    acir_pulse_if pulse_bus ();

    ac_ir_frame_encoder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pulse (pulse_bus)
    );

    pulse_entry_t pending_pulses [$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         cur_word_given;
    logic [27:0]  cur_word;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [27:0] encode_command(input logic power_on,
                                                   input logic [2:0] mode_code,
                                                   input logic [2:0] fan_code,
                                                   input logic [7:0] temp_celsius);
        logic [2:0] mode_val;
        logic [3:0] fan_val;
        logic [7:0] temp_val;
        logic [3:0] temp_field;
        logic [3:0] check;
        if (!power_on)
            return acir_pkg::OFF_WORD;
        if (mode_code == acir_pkg::MODE_COOL || mode_code == acir_pkg::MODE_DRY ||
            mode_code == acir_pkg::MODE_FAN || mode_code == acir_pkg::MODE_AUTO ||
            mode_code == acir_pkg::MODE_HEAT)
            mode_val = mode_code;
        else
            mode_val = acir_pkg::MODE_AUTO;
        if (fan_code == acir_pkg::FAN_CODE_LOW)
            fan_val = acir_pkg::FAN_VAL_LOW;
        else if (fan_code == acir_pkg::FAN_CODE_MED)
            fan_val = acir_pkg::FAN_VAL_MED;
        else if (fan_code == acir_pkg::FAN_CODE_HIGH)
            fan_val = acir_pkg::FAN_VAL_HIGH;
        else
            fan_val = acir_pkg::FAN_VAL_AUTO;
        temp_val = temp_celsius;
        if (temp_val < acir_pkg::TEMP_MIN)
            temp_val = acir_pkg::TEMP_MIN;
        if (temp_val > acir_pkg::TEMP_MAX)
            temp_val = acir_pkg::TEMP_MAX;
        temp_field = 4'(temp_val - acir_pkg::TEMP_OFFSET);
        // The power and zero nibble at bits 16..19 is always zero when the unit is on.
        check = fan_val + temp_field + {1'b0, mode_val};
        return {acir_pkg::SIGNATURE, 5'b00000, mode_val, temp_field, fan_val, check};
    endfunction

    function automatic void queue_frame(input logic [27:0] word);
        pending_pulses.push_back('{acir_pkg::HDR_MARK_US, 1'b1, 1'b0, acir_pkg::CARRIER_HZ});
        pending_pulses.push_back('{acir_pkg::HDR_SPACE_US, 1'b0, 1'b0, acir_pkg::CARRIER_HZ});
        for (int i = acir_pkg::FRAME_BITS - 1; i >= 0; i--)
        begin
            pending_pulses.push_back('{acir_pkg::BIT_MARK_US, 1'b1, 1'b0, acir_pkg::CARRIER_HZ});
            pending_pulses.push_back('{word[i] ? acir_pkg::ONE_SPACE_US : acir_pkg::ZERO_SPACE_US,
                                       1'b0, 1'b0, acir_pkg::CARRIER_HZ});
        end
        pending_pulses.push_back('{acir_pkg::BIT_MARK_US, 1'b1, 1'b0, acir_pkg::CARRIER_HZ});
        pending_pulses.push_back('{acir_pkg::GAP_US, 1'b0, 1'b1, acir_pkg::CARRIER_HZ});
    endfunction

    always @(posedge clk)
    begin
        pulse_entry_t want;
        if (rst_n)
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                queue_frame(cur_word_given ? cur_word :
                            encode_command(cmd_bus.power_on, cmd_bus.mode_code,
                                           cmd_bus.fan_code, cmd_bus.temp_celsius));
            if (pulse_bus.valid && pulse_bus.ready)
            begin
                if (pending_pulses.size() == 0)
                begin
                    $error("pulse transfer with no entry expected");
                    fail_count++;
                end
                else
                begin
                    want = pending_pulses.pop_front();
                    if (pulse_bus.duration_us !== want.duration_us)
                    begin
                        $error("duration_us: expected %0d, actual %0d",
                               want.duration_us, pulse_bus.duration_us);
                        fail_count++;
                    end
                    if (pulse_bus.is_mark !== want.is_mark)
                    begin
                        $error("is_mark: expected %0d, actual %0d",
                               want.is_mark, pulse_bus.is_mark);
                        fail_count++;
                    end
                    if (pulse_bus.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, pulse_bus.last);
                        fail_count++;
                    end
                    if (pulse_bus.carrier_hz !== want.carrier_hz)
                    begin
                        $error("carrier_hz: expected %0d, actual %0d",
                               want.carrier_hz, pulse_bus.carrier_hz);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        pulse_bus.ready = rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_command(input logic power_on, input logic [2:0] mode_code,
                                input logic [2:0] fan_code, input logic [7:0] temp_celsius,
                                input logic word_given, input logic [27:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid        = 1'b1;
        cmd_bus.power_on     = power_on;
        cmd_bus.mode_code    = mode_code;
        cmd_bus.fan_code     = fan_code;
        cmd_bus.temp_celsius = temp_celsius;
        cur_word_given       = word_given;
        cur_word             = word;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        @(negedge clk);
    endtask

    task automatic send_random_commands(input int count);
        logic [7:0] temp;
        for (int n = 0; n < count; n++)
        begin
            // Most temperatures sit near the clamp limits; a few cover the whole byte.
            if ($urandom_range(3) == 0)
                temp = 8'($urandom_range(255));
            else
                temp = 8'($urandom_range(36, 10));
            send_command($urandom_range(99) < 85, 3'($urandom_range(7)),
                         3'($urandom_range(7)), temp, 1'b0, 28'h0);
        end
    endtask

    initial
    begin
        fail_count           = 0;
        send_idle_pct        = 37;
        recv_idle_pct        = 78;
        cur_word_given       = 1'b0;
        cur_word             = 28'h0;
        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.power_on     = 1'b0;
        cmd_bus.mode_code    = 3'd0;
        cmd_bus.fan_code     = 3'd0;
        cmd_bus.temp_celsius = 8'd0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++)
            send_command(DIRECTED_ROWS[r].power_on, DIRECTED_ROWS[r].mode_code,
                         DIRECTED_ROWS[r].fan_code, DIRECTED_ROWS[r].temp_celsius,
                         DIRECTED_ROWS[r].word_given, DIRECTED_ROWS[r].word);
        send_random_commands(NUM_RANDOM / 3);

        send_idle_pct = 78;
        recv_idle_pct = 37;
        send_random_commands(NUM_RANDOM / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_commands(NUM_RANDOM - 2 * (NUM_RANDOM / 3));
        cmd_bus.valid = 1'b0;

        while (pending_pulses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
